[sv/abvt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abvt_pkg: shared constants for the adaptive band vibration trigger
// Field widths, arithmetic constants, divider sizing and register indexes.
// ----------------------------------------------------------------------------
package abvt_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int ID_BITS     = 8;
   localparam int BAND_BITS   = 8;
   localparam int BYTE_BITS   = 8;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

   // baseline update: avg = (AVG_OLD*avg + AVG_NEW*sample) / AVG_DIV
   localparam int AVG_OLD  = 7;
   localparam int AVG_NEW  = 3;
   localparam int AVG_DIV  = 10;
   localparam int BAND_MAX = 200;

   // Dividend covers sample*BAND_MAX, which also covers the baseline sum
   localparam int DIV_BITS = SAMPLE_BITS + 8;
   localparam int CNT_BITS = $clog2(DIV_BITS);

   // Reset values
   localparam logic [ID_BITS-1:0]     RST_SENSOR_ID  = ID_BITS'(2);
   localparam logic [SAMPLE_BITS-1:0] RST_FULL_SCALE = SAMPLE_BITS'(1023);
   localparam logic [SAMPLE_BITS-1:0] RST_PIEZO      = SAMPLE_BITS'(1);
   localparam logic [BAND_BITS-1:0]   RST_BAND       = BAND_BITS'(1);
   localparam logic [SAMPLE_BITS-1:0] RST_AVG        = SAMPLE_BITS'(512);
   localparam logic [SAMPLE_BITS-1:0] RST_THRESH     = SAMPLE_BITS'(127);

   typedef enum logic {
      CSR_SENSOR_ID  = 1'b0,
      CSR_FULL_SCALE = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_KNOB  = 1'b0,
      MODE_PIEZO = 1'b1
   } mode_type;

endpackage

[sv/adaptive_band_vibration_trigger.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_band_vibration_trigger: piezo band trigger with adaptive baseline
// Piezo words update a running baseline, knob words set the band and the
// thresholds; every word yields one result word with the trigger flag.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_stall  req_mode, req_sample
//  rsp_      out        rsp_valid / rsp_stall  rsp_triggered, rsp_packet_id,
//                                              rsp_piezo_byte, rsp_band_width,
//                                              rsp_baseline
//  csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
//  Each word runs through the bit-serial divider (one quotient bit per cycle),
//  then an update step folds the quotient into the state and the result.
//  One word is in flight at a time; req_stall is high from accept until the
//  result has been loaded into the output register.
//  A stalled result holds in the output register; the next word may be taken
//  while it waits. Reset is synchronous and restores all state and registers but the divider's datapath.
// ----------------------------------------------------------------------------
module adaptive_band_vibration_trigger (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [abvt_pkg::SAMPLE_BITS-1:0]    req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_triggered,
   output logic [abvt_pkg::ID_BITS-1:0]        rsp_packet_id,
   output logic [abvt_pkg::BYTE_BITS-1:0]      rsp_piezo_byte,
   output logic [abvt_pkg::BAND_BITS-1:0]      rsp_band_width,
   output logic [abvt_pkg::SAMPLE_BITS-1:0]    rsp_baseline,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [abvt_pkg::SAMPLE_BITS-1:0]    csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type                        state_ff;
   logic                             mode_ff;
   logic [abvt_pkg::SAMPLE_BITS-1:0] sample_ff;
   logic [abvt_pkg::ID_BITS-1:0]     sensor_id_ff;
   logic [abvt_pkg::SAMPLE_BITS-1:0] full_scale_ff;
   logic [abvt_pkg::SAMPLE_BITS-1:0] piezo_ff, piezo_in;
   logic [abvt_pkg::BAND_BITS-1:0]   band_ff, band_in;
   logic [abvt_pkg::SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic [abvt_pkg::SAMPLE_BITS-1:0] low_ff, low_in;
   logic [abvt_pkg::SAMPLE_BITS-1:0] high_ff, high_in;
   logic                             rsp_valid_ff;
   logic                             trig_ff, trig_in;
   logic [abvt_pkg::ID_BITS-1:0]     out_id_ff;
   logic [abvt_pkg::BYTE_BITS-1:0]   out_byte_ff;
   logic [abvt_pkg::BAND_BITS-1:0]   out_band_ff;
   logic [abvt_pkg::SAMPLE_BITS-1:0] out_avg_ff;

   logic                             accept;
   logic                             commit;
   logic [abvt_pkg::DIV_BITS-1:0]    dividend;
   logic [abvt_pkg::SAMPLE_BITS-1:0] divisor;
   logic                             div_done;
   logic [abvt_pkg::DIV_BITS-1:0]    quotient;
   logic [abvt_pkg::SAMPLE_BITS:0]   high_sum;

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign req_stall = (state_ff != ST_IDLE);
   assign commit    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   // Piezo: 7*avg + 3*sample over ten. Knob: sample*200 over full scale.
   always_comb begin
      if (req_mode == abvt_pkg::MODE_PIEZO) begin
         dividend = abvt_pkg::DIV_BITS'(avg_ff) * abvt_pkg::DIV_BITS'(abvt_pkg::AVG_OLD)
                  + abvt_pkg::DIV_BITS'(req_sample) * abvt_pkg::DIV_BITS'(abvt_pkg::AVG_NEW);
         divisor  = abvt_pkg::SAMPLE_BITS'(abvt_pkg::AVG_DIV);
      end else begin
         dividend = abvt_pkg::DIV_BITS'(req_sample)
                  * abvt_pkg::DIV_BITS'(abvt_pkg::BAND_MAX);
         divisor  = full_scale_ff;
      end
   end

   abvt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // Fold the quotient into the state and work out the trigger
   always_comb begin
      piezo_in = piezo_ff;
      band_in  = band_ff;
      avg_in   = avg_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      high_sum = '0;
      if (mode_ff == abvt_pkg::MODE_PIEZO) begin
         piezo_in = sample_ff;
         avg_in   = quotient[abvt_pkg::SAMPLE_BITS-1:0];
      end else begin
         if (quotient > abvt_pkg::DIV_BITS'(abvt_pkg::BAND_MAX)) begin
            band_in = abvt_pkg::BAND_BITS'(abvt_pkg::BAND_MAX);
         end else begin
            band_in = quotient[abvt_pkg::BAND_BITS-1:0];
         end
         // saturate low at zero and high at full range
         if (avg_ff > abvt_pkg::SAMPLE_BITS'(band_in)) begin
            low_in = avg_ff - abvt_pkg::SAMPLE_BITS'(band_in);
         end else begin
            low_in = '0;
         end
         high_sum = {1'b0, avg_ff} + (abvt_pkg::SAMPLE_BITS + 1)'(band_in);
         if (high_sum > {1'b0, abvt_pkg::SAMPLE_MAX}) begin
            high_in = abvt_pkg::SAMPLE_MAX;
         end else begin
            high_in = high_sum[abvt_pkg::SAMPLE_BITS-1:0];
         end
      end
      trig_in = (piezo_in < low_in) || (piezo_in > high_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= 1'b0;
         sample_ff     <= '0;
         sensor_id_ff  <= abvt_pkg::RST_SENSOR_ID;
         full_scale_ff <= abvt_pkg::RST_FULL_SCALE;
         piezo_ff      <= abvt_pkg::RST_PIEZO;
         band_ff       <= abvt_pkg::RST_BAND;
         avg_ff        <= abvt_pkg::RST_AVG;
         low_ff        <= abvt_pkg::RST_THRESH;
         high_ff       <= abvt_pkg::RST_THRESH;
         rsp_valid_ff  <= 1'b0;
         trig_ff       <= 1'b0;
         out_id_ff     <= '0;
         out_byte_ff   <= '0;
         out_band_ff   <= '0;
         out_avg_ff    <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               abvt_pkg::CSR_SENSOR_ID: begin
                  sensor_id_ff <= csr_data[abvt_pkg::ID_BITS-1:0];
               end
               abvt_pkg::CSR_FULL_SCALE: begin
                  full_scale_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end

         // drop the result word once taken, unless a new one replaces it
         if (rsp_valid_ff && !rsp_stall && !commit) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  mode_ff   <= req_mode;
                  sample_ff <= req_sample;
                  state_ff  <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // hold until the output register is free
               if (commit) begin
                  piezo_ff     <= piezo_in;
                  band_ff      <= band_in;
                  avg_ff       <= avg_in;
                  low_ff       <= low_in;
                  high_ff      <= high_in;
                  rsp_valid_ff <= 1'b1;
                  trig_ff      <= trig_in;
                  out_id_ff    <= sensor_id_ff;
                  out_byte_ff  <= piezo_in[abvt_pkg::BYTE_BITS-1:0];
                  out_band_ff  <= band_in;
                  out_avg_ff   <= avg_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_triggered  = trig_ff;
   assign rsp_packet_id  = out_id_ff;
   assign rsp_piezo_byte = out_byte_ff;
   assign rsp_band_width = out_band_ff;
   assign rsp_baseline   = out_avg_ff;

endmodule

[sv/abvt_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abvt_div: bit-serial restoring divider
// Shifts the dividend in one bit per cycle, one quotient bit out per cycle.
// ----------------------------------------------------------------------------
module abvt_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [abvt_pkg::DIV_BITS-1:0]        dividend,
   input  logic [abvt_pkg::SAMPLE_BITS-1:0]     divisor,
   output logic                                 done,
   output logic [abvt_pkg::DIV_BITS-1:0]        quotient
);

   logic [abvt_pkg::DIV_BITS-1:0]    shift_ff, shift_in;
   logic [abvt_pkg::SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [abvt_pkg::SAMPLE_BITS-1:0] divisor_ff, divisor_in;
   logic [abvt_pkg::CNT_BITS-1:0]    count_ff, count_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [abvt_pkg::SAMPLE_BITS:0]   trial;
   logic [abvt_pkg::SAMPLE_BITS:0]   diff;
   logic                             ge;

   // A zero divisor gives an all-ones quotient, which saturates downstream
   assign trial = {rem_ff, shift_ff[abvt_pkg::DIV_BITS-1]};
   assign ge    = trial >= {1'b0, divisor_ff};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         shift_in   = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         count_in   = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[abvt_pkg::SAMPLE_BITS-1:0] : trial[abvt_pkg::SAMPLE_BITS-1:0];
         shift_in = {shift_ff[abvt_pkg::DIV_BITS-2:0], ge};
         count_in = count_ff + 1'b1;
         if (count_ff == abvt_pkg::CNT_BITS'(abvt_pkg::DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      count_ff   <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

[sim/adaptive_band_vibration_trigger_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_band_vibration_trigger_test: self-checking bench for the trigger
// Feeds knob and piezo words through the request channel under random gaps
// and stalls, tracks baseline, band and thresholds alongside the block, and
// checks every result word field by field across several register settings.
// ----------------------------------------------------------------------------
module adaptive_band_vibration_trigger_test;

   typedef struct {
      abvt_pkg::mode_type                mode;
      logic [abvt_pkg::SAMPLE_BITS-1:0]  sample;
   } sample_word_type;

   typedef struct packed {
      logic                              triggered;
      logic [abvt_pkg::ID_BITS-1:0]      packet_id;
      logic [abvt_pkg::BYTE_BITS-1:0]    piezo_byte;
      logic [abvt_pkg::BAND_BITS-1:0]    band_width;
      logic [abvt_pkg::SAMPLE_BITS-1:0]  baseline;
   } trigger_word_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_mode = 1'b0;
   logic [abvt_pkg::SAMPLE_BITS-1:0]   req_sample = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_triggered;
   logic [abvt_pkg::ID_BITS-1:0]       rsp_packet_id;
   logic [abvt_pkg::BYTE_BITS-1:0]     rsp_piezo_byte;
   logic [abvt_pkg::BAND_BITS-1:0]     rsp_band_width;
   logic [abvt_pkg::SAMPLE_BITS-1:0]   rsp_baseline;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic                               csr_index = 1'b0;
   logic [abvt_pkg::SAMPLE_BITS-1:0]   csr_data = '0;

   // Register copies and block state as the bench tracks them
   logic [abvt_pkg::ID_BITS-1:0]       cfg_sensor_id  = abvt_pkg::RST_SENSOR_ID;
   logic [abvt_pkg::SAMPLE_BITS-1:0]   cfg_full_scale = abvt_pkg::RST_FULL_SCALE;
   logic [abvt_pkg::SAMPLE_BITS-1:0]   piezo_now = abvt_pkg::RST_PIEZO;
   logic [abvt_pkg::BAND_BITS-1:0]     band_now  = abvt_pkg::RST_BAND;
   logic [abvt_pkg::SAMPLE_BITS-1:0]   avg_now   = abvt_pkg::RST_AVG;
   logic [abvt_pkg::SAMPLE_BITS-1:0]   low_now   = abvt_pkg::RST_THRESH;
   logic [abvt_pkg::SAMPLE_BITS-1:0]   high_now  = abvt_pkg::RST_THRESH;

   sample_word_type                    samples_to_send[$];
   trigger_word_type                   trigger_words_due[$];
   abvt_pkg::mode_type                 gen_mode = abvt_pkg::MODE_KNOB;

   int                       sender_idle_pct   = 18;
   int                       receiver_idle_pct = 50;
   logic                     hold_request = 1'b0;
   int                       hold_cycles = 0;

   int                       words_queued  = 0;
   int                       words_checked = 0;
   int                       piezo_words   = 0;
   int                       knob_words    = 0;
   int                       trigger_count = 0;
   int                       csr_writes    = 0;
   int                       mismatches    = 0;

   adaptive_band_vibration_trigger i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_triggered  (rsp_triggered),
      .rsp_packet_id  (rsp_packet_id),
      .rsp_piezo_byte (rsp_piezo_byte),
      .rsp_band_width (rsp_band_width),
      .rsp_baseline   (rsp_baseline),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #1 clock = ~clock;

   // Advance the tracked state by one accepted word and queue its result
   task automatic predict_trigger(input logic mode,
                                  input logic [abvt_pkg::SAMPLE_BITS-1:0] s);
      int unsigned      acc;
      int unsigned      band;
      trigger_word_type w;
      if (mode == abvt_pkg::MODE_PIEZO) begin
         piezo_now = s;
         acc = (int'(avg_now) * abvt_pkg::AVG_OLD + int'(s) * abvt_pkg::AVG_NEW)
               / abvt_pkg::AVG_DIV;
         avg_now = abvt_pkg::SAMPLE_BITS'(acc);
         piezo_words++;
      end else begin
         if (cfg_full_scale == 0)
            band = abvt_pkg::BAND_MAX;
         else
            band = (int'(s) * abvt_pkg::BAND_MAX) / int'(cfg_full_scale);
         if (band > abvt_pkg::BAND_MAX)
            band = abvt_pkg::BAND_MAX;
         band_now = abvt_pkg::BAND_BITS'(band);
         // thresholds use the baseline as it stands now; clamp at both rails
         low_now = (avg_now > band) ? abvt_pkg::SAMPLE_BITS'(int'(avg_now) - band) : '0;
         acc = int'(avg_now) + band;
         high_now = (acc > int'(abvt_pkg::SAMPLE_MAX)) ? abvt_pkg::SAMPLE_MAX
                                                      : abvt_pkg::SAMPLE_BITS'(acc);
         knob_words++;
      end
      w.triggered  = (piezo_now < low_now) || (piezo_now > high_now);
      w.packet_id  = cfg_sensor_id;
      w.piezo_byte = piezo_now[abvt_pkg::BYTE_BITS-1:0];
      w.band_width = band_now;
      w.baseline   = avg_now;
      if (w.triggered)
         trigger_count++;
      trigger_words_due.push_back(w);
   endtask

   task automatic check_trigger_word(input trigger_word_type got);
      trigger_word_type want;
      if (trigger_words_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result word with nothing outstanding: %p", $realtime, got);
         return;
      end
      want = trigger_words_due.pop_front();
      words_checked++;
      if (got.triggered !== want.triggered || got.packet_id !== want.packet_id ||
          got.piezo_byte !== want.piezo_byte || got.band_width !== want.band_width ||
          got.baseline !== want.baseline) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: mismatch on result word %0d", $realtime, words_checked);
            $display("   expected trig %0b id %0d piezo %0d band %0d base %0d",
                     want.triggered, want.packet_id, want.piezo_byte,
                     want.band_width, want.baseline);
            $display("   actual   trig %0b id %0d piezo %0d band %0d base %0d",
                     got.triggered, got.packet_id, got.piezo_byte,
                     got.band_width, got.baseline);
         end
      end
   endtask

   // Driver: hold a word until taken, then offer the next one or idle
   always @(posedge clock) begin
      sample_word_type item;
      if (req_valid && !req_stall)
         predict_trigger(req_mode, req_sample);
      if (!req_valid || !req_stall) begin
         if (!reset && samples_to_send.size() != 0 &&
             $urandom_range(99) >= sender_idle_pct) begin
            item = samples_to_send.pop_front();
            req_valid  <= 1'b1;
            req_mode   <= item.mode;
            req_sample <= item.sample;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted down on its own
   always @(posedge clock) begin
      if (reset)
         hold_cycles <= 0;
      else if (hold_request)
         hold_cycles <= 400;
      else if (hold_cycles != 0)
         hold_cycles <= hold_cycles - 1;
   end

   // Monitor: check each taken result word, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_trigger_word({rsp_triggered, rsp_packet_id, rsp_piezo_byte,
                             rsp_band_width, rsp_baseline});
      if (reset)
         rsp_stall <= 1'b0;
      else if (hold_cycles != 0)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   task automatic queue_sample(input abvt_pkg::mode_type m, input int unsigned s);
      sample_word_type item;
      item.mode   = m;
      item.sample = abvt_pkg::SAMPLE_BITS'(s);
      samples_to_send.push_back(item);
      words_queued++;
   endtask

   // Mostly alternating knob/piezo traffic; piezo words cluster near mid-scale
   // so the baseline stays inside the band often enough to leave untriggered
   task automatic queue_random(input int count);
      int unsigned pick;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(3) != 0)
            gen_mode = (gen_mode == abvt_pkg::MODE_KNOB) ? abvt_pkg::MODE_PIEZO
                                                         : abvt_pkg::MODE_KNOB;
         else
            gen_mode = abvt_pkg::mode_type'($urandom_range(1));
         pick = $urandom_range(9);
         if (gen_mode == abvt_pkg::MODE_PIEZO) begin
            if (pick == 0)
               queue_sample(abvt_pkg::MODE_PIEZO,
                            $urandom_range(1) ? int'(abvt_pkg::SAMPLE_MAX) : 0);
            else if (pick < 4)
               queue_sample(abvt_pkg::MODE_PIEZO, $urandom_range(abvt_pkg::SAMPLE_MAX));
            else
               queue_sample(abvt_pkg::MODE_PIEZO, $urandom_range(772, 252));
         end else begin
            if (pick == 0)
               queue_sample(abvt_pkg::MODE_KNOB, 0);
            else if (pick == 1)
               queue_sample(abvt_pkg::MODE_KNOB, abvt_pkg::SAMPLE_MAX);
            else
               queue_sample(abvt_pkg::MODE_KNOB, $urandom_range(abvt_pkg::SAMPLE_MAX));
         end
      end
   endtask

   task automatic write_register(input abvt_pkg::csr_index_type idx,
                                 input logic [abvt_pkg::SAMPLE_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         abvt_pkg::CSR_SENSOR_ID:  cfg_sensor_id  = value[abvt_pkg::ID_BITS-1:0];
         abvt_pkg::CSR_FULL_SCALE: cfg_full_scale = value;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic drain;
      wait (words_checked == words_queued);
      @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: the first result is already triggered
      queue_sample(abvt_pkg::MODE_PIEZO, 1);
      queue_sample(abvt_pkg::MODE_PIEZO, 0);
      queue_sample(abvt_pkg::MODE_PIEZO, abvt_pkg::SAMPLE_MAX);
      queue_sample(abvt_pkg::MODE_KNOB, 0);
      queue_sample(abvt_pkg::MODE_KNOB, abvt_pkg::SAMPLE_MAX);
      // drive the baseline to the top so the high threshold clamps
      for (int k = 0; k < 6; k++)
         queue_sample(abvt_pkg::MODE_PIEZO, abvt_pkg::SAMPLE_MAX);
      queue_sample(abvt_pkg::MODE_KNOB, abvt_pkg::SAMPLE_MAX);
      // and to the bottom so the low threshold clamps
      for (int k = 0; k < 6; k++)
         queue_sample(abvt_pkg::MODE_PIEZO, 0);
      queue_sample(abvt_pkg::MODE_KNOB, abvt_pkg::SAMPLE_MAX);
      queue_sample(abvt_pkg::MODE_PIEZO, 512);
      queue_sample(abvt_pkg::MODE_KNOB, 511);
      drain();

      // Zero full scale: band pinned at its maximum
      write_register(abvt_pkg::CSR_SENSOR_ID, abvt_pkg::SAMPLE_MAX);
      write_register(abvt_pkg::CSR_FULL_SCALE, abvt_pkg::SAMPLE_BITS'(0));
      queue_sample(abvt_pkg::MODE_KNOB, 0);
      queue_sample(abvt_pkg::MODE_PIEZO, 300);
      queue_sample(abvt_pkg::MODE_KNOB, abvt_pkg::SAMPLE_MAX);
      queue_sample(abvt_pkg::MODE_PIEZO, 700);
      queue_sample(abvt_pkg::MODE_KNOB, 5);
      queue_random(60);
      drain();

      write_register(abvt_pkg::CSR_SENSOR_ID, abvt_pkg::SAMPLE_BITS'(0));
      write_register(abvt_pkg::CSR_FULL_SCALE, abvt_pkg::SAMPLE_BITS'(1));
      queue_random(150);
      drain();

      // Knob mostly above full scale; swap the idle pattern
      sender_idle_pct   <= 50;
      receiver_idle_pct <= 18;
      write_register(abvt_pkg::CSR_SENSOR_ID,
                     abvt_pkg::SAMPLE_BITS'($urandom_range(abvt_pkg::SAMPLE_MAX)));
      write_register(abvt_pkg::CSR_FULL_SCALE, abvt_pkg::SAMPLE_BITS'(100));
      queue_random(150);
      drain();

      // No idling; hold the receiver off while words keep coming
      sender_idle_pct   <= 0;
      receiver_idle_pct <= 0;
      write_register(abvt_pkg::CSR_SENSOR_ID,
                     abvt_pkg::SAMPLE_BITS'($urandom_range(abvt_pkg::SAMPLE_MAX)));
      write_register(abvt_pkg::CSR_FULL_SCALE, abvt_pkg::SAMPLE_MAX);
      @(posedge clock);
      hold_request <= 1'b1;
      queue_random(150);
      @(posedge clock);
      hold_request <= 1'b0;
      drain();

      write_register(abvt_pkg::CSR_SENSOR_ID,
                     abvt_pkg::SAMPLE_BITS'($urandom_range(abvt_pkg::SAMPLE_MAX)));
      write_register(abvt_pkg::CSR_FULL_SCALE,
                     abvt_pkg::SAMPLE_BITS'($urandom_range(abvt_pkg::SAMPLE_MAX, 1)));
      queue_random(200);
      drain();

      write_register(abvt_pkg::CSR_FULL_SCALE, abvt_pkg::SAMPLE_BITS'(512));
      queue_random(100);
      drain();

      repeat (50) @(posedge clock);
      if (trigger_words_due.size() != 0) begin
         mismatches++;
         $display("%0d result words never arrived", trigger_words_due.size());
      end
      $display("Ran %0d words (%0d piezo, %0d knob) over %0d register writes;",
               words_checked, piezo_words, knob_words, csr_writes);
      $display("%0d results fired the trigger, %0d mismatches.",
               trigger_count, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out with %0d of %0d words checked", words_checked, words_queued);
      $display("simulation failed");
      $finish;
   end

endmodule
